/* rtl/sqg_pkg.sv */
// sqg_pkg: shared types and constants for the single-qubit gate engine.
// Used by sqg_ctrl, sqg_dp, the top level and the checker; depends on nothing.
`default_nettype none
package sqg_pkg;

  localparam logic [1:0] REQ_INIT = 2'd0;
  localparam logic [1:0] REQ_GATE = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam int GATE_FRAC = 14;
  localparam int GATE_W    = 16;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_DISP = 9'b0_0000_0010,
    ST_INIT = 9'b0_0000_0100,
    ST_GRD  = 9'b0_0000_1000,
    ST_GMUL = 9'b0_0001_0000,
    ST_GADD = 9'b0_0010_0000,
    ST_GWR0 = 9'b0_0100_0000,
    ST_GWR1 = 9'b0_1000_0000,
    ST_DONE = 9'b1_0000_0000
  } state_t;

  typedef struct packed {
    logic load_req;   // capture request fields
    logic clr_ctr;
    logic inc_ctr;
    logic mem_rd_pair;
    logic mem_rd_one;
    logic mul_en;
    logic add_en;
    logic wr_init;
    logic wr_top;
    logic wr_bot;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       target_ok;
    logic       init_last;
    logic       pair_last;
    logic       out_free;
  } status_t;

endpackage
`default_nettype wire

/* rtl/sqg_mem.sv */
// sqg_mem: amplitude store, one write port and two registered read ports.
// Depends on nothing.
`default_nettype none
module sqg_mem #(
  parameter int AW = 10,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output logic      [DW-1:0] rdata_a,
  output logic      [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

/* rtl/sqg_ctrl.sv */
// sqg_ctrl: request sequencer for init sweeps, gate pair sweeps and reads.
// Depends on sqg_pkg; drives sqg_dp through cmd_t and watches status_t.
`default_nettype none
module sqg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire sqg_pkg::status_t sts,
  output sqg_pkg::cmd_t         cmd
);

  sqg_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sqg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == sqg_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      sqg_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_req = 1'b1;
          cmd.clr_ctr  = 1'b1;
          state_next   = sqg_pkg::ST_DISP;
        end
      end
      // branch on the captured request type
      sqg_pkg::ST_DISP: begin
        case (sts.req_type)
          sqg_pkg::REQ_INIT: state_next = sqg_pkg::ST_INIT;
          sqg_pkg::REQ_GATE: state_next = sts.target_ok ? sqg_pkg::ST_GRD : sqg_pkg::ST_DONE;
          sqg_pkg::REQ_READ: begin
            cmd.mem_rd_one = 1'b1;
            state_next     = sqg_pkg::ST_DONE;
          end
          default: state_next = sqg_pkg::ST_DONE;
        endcase
      end
      sqg_pkg::ST_INIT: begin
        cmd.wr_init = 1'b1;
        cmd.inc_ctr = 1'b1;
        if (sts.init_last) begin
          state_next = sqg_pkg::ST_DONE;
        end
      end
      sqg_pkg::ST_GRD: begin
        cmd.mem_rd_pair = 1'b1;
        state_next      = sqg_pkg::ST_GMUL;
      end
      sqg_pkg::ST_GMUL: begin
        cmd.mul_en = 1'b1;
        state_next = sqg_pkg::ST_GADD;
      end
      sqg_pkg::ST_GADD: begin
        cmd.add_en = 1'b1;
        state_next = sqg_pkg::ST_GWR0;
      end
      sqg_pkg::ST_GWR0: begin
        cmd.wr_top = 1'b1;
        state_next = sqg_pkg::ST_GWR1;
      end
      sqg_pkg::ST_GWR1: begin
        cmd.wr_bot = 1'b1;
        cmd.inc_ctr = 1'b1;
        state_next = sts.pair_last ? sqg_pkg::ST_DONE : sqg_pkg::ST_GRD;
      end
      sqg_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = sqg_pkg::ST_IDLE;
        end
      end
      default: state_next = sqg_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/sqg_dp.sv */
// sqg_dp: request registers, sweep counter, complex gate arithmetic and result register.
// Depends on sqg_pkg and sqg_mem.
`default_nettype none
module sqg_dp #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sqg_pkg::cmd_t    cmd,
  output sqg_pkg::status_t      sts,
  input  wire logic [1:0]       req_type,
  input  wire logic [141:0]     req_data,
  input  wire logic [3:0]       num_qubits,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [1:0]            m_tuser,
  output logic [31:0]           m_tdata
);

  localparam int AW = MAX_QUBITS;
  localparam int PW = AMP_WIDTH + sqg_pkg::GATE_W;
  localparam int SW = PW + 3;

  logic [1:0]  req;
  logic [9:0]  bidx;
  logic [3:0]  tq;
  logic signed [sqg_pkg::GATE_W-1:0] g [8];
  logic [AW-1:0] ctr;

  logic [4:0]  n_eff;
  logic [31:0] size_mask, half_m1, bitmask, lowm, ctr_ext, a0_w, idx_w;
  logic [AW-1:0] a0, a1, idx;

  always_comb begin
    if (num_qubits == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, num_qubits} > 5'(MAX_QUBITS)) begin
      n_eff = 5'(MAX_QUBITS);
    end else begin
      n_eff = {1'b0, num_qubits};
    end
    size_mask = (32'd1 << n_eff) - 32'd1;
    half_m1   = (32'd1 << (n_eff - 5'd1)) - 32'd1;
    bitmask   = 32'd1 << tq;
    lowm      = bitmask - 32'd1;
    ctr_ext   = 32'(ctr);
    a0_w      = (ctr_ext & lowm) | ((ctr_ext & ~lowm) << 1);
    idx_w     = 32'(bidx) & size_mask;
    a0        = a0_w[AW-1:0];
    a1        = a0 | bitmask[AW-1:0];
    idx       = idx_w[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req  <= req_type;
      bidx <= req_data[9:0];
      tq   <= req_data[13:10];
      for (int k = 0; k < 8; k++) begin
        g[k] <= req_data[14 + 16*k +: 16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.clr_ctr) begin
      ctr <= '0;
    end else if (cmd.inc_ctr) begin
      ctr <= ctr + AW'(1);
    end
  end

  // memory hookup
  logic          we;
  logic [AW-1:0] waddr, raddr_a;
  logic [2*AMP_WIDTH-1:0] wdata, rd_a, rd_b;
  logic signed [AMP_WIDTH-1:0] top_re, top_im, bot_re, bot_im;

  always_comb begin
    we    = cmd.wr_init | cmd.wr_top | cmd.wr_bot;
    waddr = cmd.wr_init ? ctr : (cmd.wr_bot ? a1 : a0);
    if (cmd.wr_init) begin
      wdata = (ctr == idx) ? (2*AMP_WIDTH)'(1) << (AMP_WIDTH - 2) : '0;
    end else if (cmd.wr_bot) begin
      wdata = {bot_im, bot_re};
    end else begin
      wdata = {top_im, top_re};
    end
    raddr_a = cmd.mem_rd_one ? idx : a0;
  end

  sqg_mem #(.AW(AW), .DW(2*AMP_WIDTH)) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (cmd.mem_rd_pair | cmd.mem_rd_one),
    .raddr_a (raddr_a),
    .raddr_b (a1),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // products: per row r (0 top, 1 bottom), per column c: re terms and im terms
  logic signed [AMP_WIDTH-1:0] xr, xi, yr, yi;
  logic signed [PW-1:0] p [16];

  assign xr = rd_a[AMP_WIDTH-1:0];
  assign xi = rd_a[2*AMP_WIDTH-1:AMP_WIDTH];
  assign yr = rd_b[AMP_WIDTH-1:0];
  assign yi = rd_b[2*AMP_WIDTH-1:AMP_WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      for (int r = 0; r < 2; r++) begin
        p[8*r+0] <= PW'(xr * g[4*r+0]);
        p[8*r+1] <= PW'(xi * g[4*r+1]);
        p[8*r+2] <= PW'(xr * g[4*r+1]);
        p[8*r+3] <= PW'(xi * g[4*r+0]);
        p[8*r+4] <= PW'(yr * g[4*r+2]);
        p[8*r+5] <= PW'(yi * g[4*r+3]);
        p[8*r+6] <= PW'(yr * g[4*r+3]);
        p[8*r+7] <= PW'(yi * g[4*r+2]);
      end
    end
  end

  function automatic logic signed [PW+1:0] rnd(input logic signed [PW:0] v);
    logic signed [PW+1:0] t;
    t = PW'(0) + (PW+2)'(v) + (PW+2)'(signed'(1 <<< (sqg_pkg::GATE_FRAC - 1)));
    return t >>> sqg_pkg::GATE_FRAC;
  endfunction

  function automatic logic signed [AMP_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    hi = SW'((64'sd1 <<< (AMP_WIDTH - 1)) - 64'sd1);
    lo = -hi - SW'(1);
    if (v > hi) return hi[AMP_WIDTH-1:0];
    else if (v < lo) return lo[AMP_WIDTH-1:0];
    else return v[AMP_WIDTH-1:0];
  endfunction

  logic signed [SW-1:0] s [4];

  always_comb begin
    for (int r = 0; r < 2; r++) begin
      s[2*r]   = SW'(rnd((PW+1)'(p[8*r+0]) - (PW+1)'(p[8*r+1])))
               + SW'(rnd((PW+1)'(p[8*r+4]) - (PW+1)'(p[8*r+5])));
      s[2*r+1] = SW'(rnd((PW+1)'(p[8*r+2]) + (PW+1)'(p[8*r+3])))
               + SW'(rnd((PW+1)'(p[8*r+6]) + (PW+1)'(p[8*r+7])));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_en) begin
      top_re <= sat(s[0]);
      top_im <= sat(s[1]);
      bot_re <= sat(s[2]);
      bot_im <= sat(s[3]);
    end
  end

  // result register
  logic signed [31:0] ore, oim;
  assign ore = 32'(signed'(rd_a[AMP_WIDTH-1:0]));
  assign oim = 32'(signed'(rd_a[2*AMP_WIDTH-1:AMP_WIDTH]));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tuser <= req;
      m_tdata <= (req == sqg_pkg::REQ_READ) ? {oim[15:0], ore[15:0]} : 32'd0;
    end
  end

  always_comb begin
    sts.req_type  = req;
    sts.target_ok = ({1'b0, tq} < n_eff);
    sts.init_last = &ctr;
    sts.pair_last = (ctr == half_m1[AW-1:0]);
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule
`default_nettype wire

/* rtl/single_qubit_gate_state_update.sv */
// Channel | Dir | Payload
// s       | in  | tuser: req_type; tdata: basis_index, target_qubit, g00..g11 re/im
// m       | out | tuser: req_echo; tdata: amp_re, amp_im
// cfg     | in  | cfg_data: num_qubits
//
// One request at a time; s_tready is high only while the sequencer is idle.
// Init writes all 2^MAX_QUBITS store words, one store write per cycle; gate sweeps the
// 2^(n-1) pairs (read, multiply, round/sum, two writes per pair on the single write
// port); target out of range, read and unknown type go straight to the result.
// Reset clears the sequencer, result valid and num_qubits (to 1); the store is not
// cleared. A stalled result holds the next request in the sequencer's final state.
// Top level of the single-qubit gate engine; depends on sqg_pkg, sqg_ctrl, sqg_dp.
`default_nettype none
module single_qubit_gate_state_update #(
  parameter int MAX_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [1:0]   s_tuser,   // req_type
  // basis_index, target_qubit, g00_re, g00_im, g01_re, g01_im,
  // g10_re, g10_im, g11_re, g11_im, 2 pad bits
  input  wire logic [143:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [1:0]        m_tuser,   // req_echo
  output logic [31:0]       m_tdata,   // amp_re, amp_im
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data
);

  logic [3:0] num_qubits;
  sqg_pkg::cmd_t    cmd;
  sqg_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_qubits <= 4'd1;
    end else if (cfg_valid) begin
      num_qubits <= cfg_data;
    end
  end

  sqg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sqg_dp #(.MAX_QUBITS(MAX_QUBITS), .AMP_WIDTH(AMP_WIDTH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (s_tuser),
    .req_data   (s_tdata[141:0]),
    .num_qubits (num_qubits),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tuser    (m_tuser),
    .m_tdata    (m_tdata)
  );

endmodule
`default_nettype wire

/* rtl/sqg_checker.sv */
// sqg_checker: port-level assertions for single_qubit_gate_state_update.
// Bound to the top level below; depends on sqg_pkg.
`default_nettype none
module sqg_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [1:0]  m_tuser,
  input wire logic [31:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while another is in flight");

  a_zero_amp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != sqg_pkg::REQ_READ |-> m_tdata == 32'd0)
    else $error("nonzero amplitude on a non-read result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind single_qubit_gate_state_update sqg_checker u_sqg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tuser  (m_tuser),
  .m_tdata  (m_tdata)
);
`default_nettype wire
